// ===== sv/npcs_pkg.sv =====
// Shared constants and types of the nearest palette color search unit.
`default_nettype none
package npcs_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int SLOT_W          = $clog2(PALETTE_ENTRIES);
    localparam int INDEX_W         = 8;
    localparam int CHAN_W          = 8;
    localparam int WEIGHT_W        = 10;
    localparam int SQ_W            = 2 * CHAN_W;
    localparam int PROD_W          = SQ_W + WEIGHT_W;
    localparam int DIST_W          = 28;
    localparam int COLOR_W         = 3 * CHAN_W;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_RED_WEIGHT   = 2'd0;
    localparam logic [1:0] REG_GREEN_WEIGHT = 2'd1;
    localparam logic [1:0] REG_BLUE_WEIGHT  = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(1);

    // Input opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic query_load;   // latch query color, restart scan
        logic wr_en;        // store palette entry
        logic scan_step;    // read one palette entry
        logic result_load;  // move result into output register
    } npcs_cmd_t;

    typedef struct packed {
        logic loaded;
        logic scan_last;
        logic pipe_busy;
    } npcs_status_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] match_index;
        logic [DIST_W-1:0]  match_distance;
        logic               exact_match;
    } npcs_result_t;

endpackage
`default_nettype wire

// ===== sv/npcs_ctrl.sv =====
// Control state machine of the nearest palette color search unit.
`default_nettype none
module npcs_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_opcode,
    output logic                       in_ready,
    input  wire logic                  out_free,
    input  wire npcs_pkg::npcs_status_t status,
    output npcs_pkg::npcs_cmd_t        cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       in_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (in_opcode == npcs_pkg::OP_WRITE))
                begin
                    cmd.wr_en = 1'b1;
                end
                else if (in_fire)
                begin
                    cmd.query_load = 1'b1;
                    state_next     = status.loaded ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/npcs_datapath.sv =====
// Palette memory, distance pipeline and running minimum.
`default_nettype none
module npcs_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire npcs_pkg::npcs_cmd_t                 cmd,
    input  wire logic [npcs_pkg::INDEX_W-1:0]        entry_index,
    input  wire logic [npcs_pkg::CHAN_W-1:0]         color_red,
    input  wire logic [npcs_pkg::CHAN_W-1:0]         color_green,
    input  wire logic [npcs_pkg::CHAN_W-1:0]         color_blue,
    input  wire logic [npcs_pkg::WEIGHT_W-1:0]       red_weight,
    input  wire logic [npcs_pkg::WEIGHT_W-1:0]       green_weight,
    input  wire logic [npcs_pkg::WEIGHT_W-1:0]       blue_weight,
    output npcs_pkg::npcs_status_t                   status,
    output npcs_pkg::npcs_result_t                   result
);

    localparam int CW = npcs_pkg::CHAN_W;

    logic [npcs_pkg::COLOR_W-1:0] palette_mem [npcs_pkg::PALETTE_ENTRIES];

    logic                          loaded_reg;
    logic [CW-1:0]                 q_red_reg;
    logic [CW-1:0]                 q_green_reg;
    logic [CW-1:0]                 q_blue_reg;
    logic [npcs_pkg::SLOT_W-1:0]   addr_reg;

    // stage 1: entry read
    logic                          v1_reg;
    logic [npcs_pkg::SLOT_W-1:0]   idx1_reg;
    logic [npcs_pkg::COLOR_W-1:0]  rd_data_reg;
    // stage 2: squared differences
    logic                          v2_reg;
    logic [npcs_pkg::SLOT_W-1:0]   idx2_reg;
    logic [npcs_pkg::SQ_W-1:0]     sq_r_reg;
    logic [npcs_pkg::SQ_W-1:0]     sq_g_reg;
    logic [npcs_pkg::SQ_W-1:0]     sq_b_reg;
    // stage 3: weighted products
    logic                          v3_reg;
    logic [npcs_pkg::SLOT_W-1:0]   idx3_reg;
    logic [npcs_pkg::PROD_W-1:0]   p_r_reg;
    logic [npcs_pkg::PROD_W-1:0]   p_g_reg;
    logic [npcs_pkg::PROD_W-1:0]   p_b_reg;
    // stage 4: distance
    logic                          v4_reg;
    logic [npcs_pkg::SLOT_W-1:0]   idx4_reg;
    logic [npcs_pkg::DIST_W-1:0]   dist_reg;
    // running minimum
    logic                          best_valid_reg;
    logic [npcs_pkg::SLOT_W-1:0]   best_idx_reg;
    logic [npcs_pkg::DIST_W-1:0]   best_dist_reg;

    logic          wr_ok;
    logic [CW-1:0] d_r;
    logic [CW-1:0] d_g;
    logic [CW-1:0] d_b;
    logic [CW-1:0] e_r;
    logic [CW-1:0] e_g;
    logic [CW-1:0] e_b;

    assign wr_ok = cmd.wr_en && (32'(entry_index) < 32'(npcs_pkg::PALETTE_ENTRIES));

    assign e_r = rd_data_reg[3*CW-1:2*CW];
    assign e_g = rd_data_reg[2*CW-1:CW];
    assign e_b = rd_data_reg[CW-1:0];
    assign d_r = (q_red_reg   >= e_r) ? (q_red_reg   - e_r) : (e_r - q_red_reg);
    assign d_g = (q_green_reg >= e_g) ? (q_green_reg - e_g) : (e_g - q_green_reg);
    assign d_b = (q_blue_reg  >= e_b) ? (q_blue_reg  - e_b) : (e_b - q_blue_reg);

    // Palette memory: writes only while idle, reads only while scanning.
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            palette_mem[npcs_pkg::SLOT_W'(entry_index)] <=
                {color_red, color_green, color_blue};
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= palette_mem[addr_reg];
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.query_load)
        begin
            q_red_reg   <= color_red;
            q_green_reg <= color_green;
            q_blue_reg  <= color_blue;
        end
        idx1_reg <= addr_reg;
        idx2_reg <= idx1_reg;
        sq_r_reg <= npcs_pkg::SQ_W'(d_r) * npcs_pkg::SQ_W'(d_r);
        sq_g_reg <= npcs_pkg::SQ_W'(d_g) * npcs_pkg::SQ_W'(d_g);
        sq_b_reg <= npcs_pkg::SQ_W'(d_b) * npcs_pkg::SQ_W'(d_b);
        idx3_reg <= idx2_reg;
        p_r_reg  <= npcs_pkg::PROD_W'(sq_r_reg) * npcs_pkg::PROD_W'(red_weight);
        p_g_reg  <= npcs_pkg::PROD_W'(sq_g_reg) * npcs_pkg::PROD_W'(green_weight);
        p_b_reg  <= npcs_pkg::PROD_W'(sq_b_reg) * npcs_pkg::PROD_W'(blue_weight);
        idx4_reg <= idx3_reg;
        dist_reg <= npcs_pkg::DIST_W'(p_r_reg) + npcs_pkg::DIST_W'(p_g_reg)
                  + npcs_pkg::DIST_W'(p_b_reg);
    end

    // Control of scan and minimum tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg     <= 1'b0;
            addr_reg       <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                loaded_reg <= 1'b1;
            end
            if (cmd.query_load)
            begin
                addr_reg       <= '0;
                best_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            v1_reg <= cmd.scan_step;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (v4_reg)
            begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    // Strict less-than keeps the lowest index on ties.
    always_ff @(posedge clk)
    begin
        if (v4_reg && (!best_valid_reg || (dist_reg < best_dist_reg)))
        begin
            best_dist_reg <= dist_reg;
            best_idx_reg  <= idx4_reg;
        end
    end

    assign status.loaded    = loaded_reg;
    assign status.scan_last = (addr_reg == npcs_pkg::SLOT_W'(npcs_pkg::PALETTE_ENTRIES - 1));
    assign status.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;

    assign result.found          = loaded_reg;
    assign result.match_index    = loaded_reg ? npcs_pkg::INDEX_W'(best_idx_reg) : '0;
    assign result.match_distance = loaded_reg ? best_dist_reg : '0;
    assign result.exact_match    = loaded_reg && (best_dist_reg == '0);

endmodule
`default_nettype wire

// ===== sv/nearest_palette_color_search_unit.sv =====
// Top level of the nearest palette color search unit.
// Holds a 256-entry palette of 24-bit RGB colors. An input transfer with
// s_tuser = 0 writes one palette entry and gives no result. A transfer
// with s_tuser = 1 queries: every entry is read in index order from the
// single-port palette memory, one entry per clock, and its weighted squared
// distance red_weight*dr^2 + green_weight*dg^2 + blue_weight*db^2 goes
// through a four-stage pipeline (read, square, weight, sum) into a running
// minimum. The result names the lowest index with the smallest distance.
// A query made before any entry is written returns found = 0 with all
// other fields zero. One query is in flight at a time; input is taken
// again as soon as the result is in the output register, even while that
// result waits for m_tready. Entries never written hold no defined color,
// so fill the palette before querying. Weights are written over APB at
// 0x0 (red), 0x4 (green) and 0x8 (blue), reset to 1, and may change only
// while idle.
`default_nettype none
module nearest_palette_color_search_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // APB configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [npcs_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [npcs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [npcs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [31:0]                       s_tdata,  // entry_index, color_red, color_green, color_blue
    input  wire logic                              s_tuser,  // opcode
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [39:0]                       m_tdata,  // match_index, match_distance, exact_match, zero pad
    output logic                                   m_tuser   // found
);

    logic [npcs_pkg::WEIGHT_W-1:0] red_weight_reg;
    logic [npcs_pkg::WEIGHT_W-1:0] green_weight_reg;
    logic [npcs_pkg::WEIGHT_W-1:0] blue_weight_reg;

    logic                   cfg_wr;
    npcs_pkg::npcs_cmd_t    cmd;
    npcs_pkg::npcs_status_t status;
    npcs_pkg::npcs_result_t result;

    logic                   m_tvalid_reg;
    npcs_pkg::npcs_result_t out_reg;
    logic                   out_free;

    // APB: always ready, write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_weight_reg   <= npcs_pkg::WEIGHT_RESET;
            green_weight_reg <= npcs_pkg::WEIGHT_RESET;
            blue_weight_reg  <= npcs_pkg::WEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                npcs_pkg::REG_RED_WEIGHT:   red_weight_reg   <= pwdata[npcs_pkg::WEIGHT_W-1:0];
                npcs_pkg::REG_GREEN_WEIGHT: green_weight_reg <= pwdata[npcs_pkg::WEIGHT_W-1:0];
                npcs_pkg::REG_BLUE_WEIGHT:  blue_weight_reg  <= pwdata[npcs_pkg::WEIGHT_W-1:0];
                default:
                begin
                    // unmapped address: write dropped
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            npcs_pkg::REG_RED_WEIGHT:   prdata = npcs_pkg::APB_DATA_W'(red_weight_reg);
            npcs_pkg::REG_GREEN_WEIGHT: prdata = npcs_pkg::APB_DATA_W'(green_weight_reg);
            npcs_pkg::REG_BLUE_WEIGHT:  prdata = npcs_pkg::APB_DATA_W'(blue_weight_reg);
            default:                    prdata = '0;
        endcase
    end

    // Output register frees when empty or drained in the same cycle
    assign out_free = !m_tvalid_reg || m_tready;

    npcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_opcode (s_tuser),
        .in_ready  (s_tready),
        .out_free  (out_free),
        .status    (status),
        .cmd       (cmd)
    );

    npcs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .entry_index  (s_tdata[7:0]),
        .color_red    (s_tdata[15:8]),
        .color_green  (s_tdata[23:16]),
        .color_blue   (s_tdata[31:24]),
        .red_weight   (red_weight_reg),
        .green_weight (green_weight_reg),
        .blue_weight  (blue_weight_reg),
        .status       (status),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.found;
    assign m_tdata  = {3'b000, out_reg.exact_match, out_reg.match_distance,
                       out_reg.match_index};

endmodule
`default_nettype wire
